// ===== rtl/assert_macros.svh =====
// assertion macros used by the matcher rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// ===== rtl/ksm_pkg.sv =====
// types, constants and helpers of the k-mer seed table matcher
package ksm_pkg;
  localparam int unsigned TableDepth = 1024;
  localparam int unsigned PosBits    = 20;
  localparam int unsigned AddrBits   = $clog2(TableDepth);
  localparam int unsigned CntBits    = AddrBits + 1;

  localparam logic [1:0] OpClear = 2'd0;
  localparam logic [1:0] OpBaseA = 2'd1;
  localparam logic [1:0] OpBaseB = 2'd2;
  localparam logic [1:0] OpRead  = 2'd3;

  localparam logic [1:0] CfgMerSize   = 2'd0;
  localparam logic [1:0] CfgDupIgnore = 2'd1;
  localparam logic [1:0] CfgMinDiag   = 2'd2;
  localparam logic [1:0] CfgMaxDiag   = 2'd3;

  localparam logic [1:0] BNone = 2'd0;
  localparam logic [1:0] BRec  = 2'd1;
  localparam logic [1:0] BDup  = 2'd2;

  typedef struct packed {
    logic [63:0]        kmer;
    logic [PosBits-1:0] a_pos;
    logic               a_dup;
    logic [PosBits-1:0] b_pos;
    logic [1:0]         b_state;
  } entry_t;

  localparam int unsigned EntryBits = $bits(entry_t);

  function automatic logic [5:0] eff_k(input logic [5:0] k);
    if (k == 6'd0) return 6'd1;
    if (k > 6'd32) return 6'd32;
    return k;
  endfunction
endpackage

// ===== rtl/ksm_ram.sv =====
// generic single write port ram with registered read
module ksm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    if (re_i) rdata_o <= mem[raddr_i];
  end
endmodule

// ===== rtl/kmer_seed_table_matcher.sv =====
// k-mer seed table matcher: clear and invalid k-mers are answered from idle, read entry via the
// read state after a registered table read, a base by a linear search of the table (one slot per
// cycle through the single table ram read port); one item in flight at a time.
// reset: async active low, clears k-mer register, sets validity to all ones, count to zero,
// config to mer size 16, dup ignore on, diagonals zero. table ram is not cleared;
// slots at or above the count never contribute to a result.
`include "assert_macros.svh"
module kmer_seed_table_matcher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic        restart_i,
  input  logic [7:0]  base_char_i,
  input  logic [19:0] position_i,
  input  logic [9:0]  entry_index_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        status_o,
  output logic        hit_valid_o,
  output logic [19:0] hit_a_pos_o,
  output logic [19:0] hit_b_pos_o,
  output logic [5:0]  hit_length_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [20:0] cfg_data_i
);
  typedef enum logic [1:0] {StIdle, StSearch, StRead} state_e;

  state_e state_q;
  logic [5:0]  mer_size_q;
  logic        dup_ignore_q;
  logic signed [20:0] min_diag_q, max_diag_q;
  logic [63:0] kmer_q, vshift_q;
  logic [ksm_pkg::CntBits-1:0]  count_q, addr_q;
  logic [ksm_pkg::AddrBits-1:0] pidx_q;
  logic        pend_q;
  logic [1:0]  op_q;
  logic [19:0] pos_q;
  logic [9:0]  idx_q;
  logic        out_valid_q, status_q, hv_q;
  logic [19:0] ha_q, hb_q;
  logic [5:0]  hl_q;

  logic        accept;
  logic [5:0]  k_eff;
  logic [63:0] kmask, kmer_d, vshift_d, k_base, v_base;
  logic [1:0]  code, bad;
  logic [19:0] start_pos;
  logic        we, re;
  logic [ksm_pkg::AddrBits-1:0] waddr, raddr;
  ksm_pkg::entry_t wdata, rdata;
  logic        match;
  logic signed [21:0] diag;
  logic        in_range;

  assign accept      = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == StIdle) && !out_valid_q;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign hit_valid_o = hv_q;
  assign hit_a_pos_o = ha_q;
  assign hit_b_pos_o = hb_q;
  assign hit_length_o = hl_q;

  assign k_eff = ksm_pkg::eff_k(mer_size_q);
  assign kmask = (k_eff >= 6'd32) ? '1 : ~({64{1'b1}} << {k_eff, 1'b0});

  always_comb begin
    case (base_char_i)
      8'h41, 8'h61: begin code = 2'd0; bad = 2'd0; end
      8'h43, 8'h63: begin code = 2'd1; bad = 2'd0; end
      8'h47, 8'h67: begin code = 2'd2; bad = 2'd0; end
      8'h54, 8'h74: begin code = 2'd3; bad = 2'd0; end
      default:      begin code = 2'd0; bad = 2'd3; end
    endcase
  end

  assign k_base   = restart_i ? '0 : kmer_q;
  assign v_base   = restart_i ? '1 : vshift_q;
  assign kmer_d   = {k_base[61:0], code} & kmask;
  assign vshift_d = {v_base[61:0], bad} & kmask;

  assign start_pos = pos_q + 20'd1 - {14'd0, k_eff};
  assign match     = pend_q && (rdata.kmer == kmer_q);
  assign diag      = $signed({2'b00, rdata.a_pos}) - $signed({2'b00, start_pos});
  assign in_range  = (diag >= 22'(min_diag_q)) && (diag <= 22'(max_diag_q));

  // table access: search reads, read-entry read, one write of the updated or newly inserted slot
  always_comb begin
    re    = 1'b0;
    raddr = addr_q[ksm_pkg::AddrBits-1:0];
    we    = 1'b0;
    waddr = pidx_q;
    wdata = rdata;
    if (accept && operation_i == ksm_pkg::OpRead) begin
      re    = 1'b1;
      raddr = entry_index_i;
    end else if (state_q == StSearch) begin
      if (match) begin
        if (op_q == ksm_pkg::OpBaseA) begin
          we = dup_ignore_q;
          wdata.a_dup = 1'b1;
        end else if (!rdata.a_dup && in_range) begin
          if (rdata.b_state != ksm_pkg::BNone) begin
            we = dup_ignore_q;
            wdata.b_state = ksm_pkg::BDup;
          end else begin
            we = 1'b1;
            wdata.b_state = ksm_pkg::BRec;
            wdata.b_pos = start_pos;
          end
        end
      end else if (addr_q < count_q) begin
        re = 1'b1;
      end else if (op_q == ksm_pkg::OpBaseA && count_q < ksm_pkg::CntBits'(ksm_pkg::TableDepth)) begin
        we    = 1'b1;
        waddr = count_q[ksm_pkg::AddrBits-1:0];
        wdata = '{kmer: kmer_q, a_pos: start_pos, a_dup: 1'b0, b_pos: '0,
                  b_state: ksm_pkg::BNone};
      end
    end
  end

  ksm_ram #(.Width(ksm_pkg::EntryBits), .Depth(ksm_pkg::TableDepth)) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      mer_size_q   <= 6'd16;
      dup_ignore_q <= 1'b1;
      min_diag_q   <= '0;
      max_diag_q   <= '0;
      kmer_q       <= '0;
      vshift_q     <= '1;
      count_q      <= '0;
      addr_q       <= '0;
      pidx_q       <= '0;
      pend_q       <= 1'b0;
      op_q         <= ksm_pkg::OpClear;
      pos_q        <= '0;
      idx_q        <= '0;
      out_valid_q  <= 1'b0;
      status_q     <= 1'b0;
      hv_q         <= 1'b0;
      ha_q         <= '0;
      hb_q         <= '0;
      hl_q         <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          ksm_pkg::CfgMerSize:   mer_size_q   <= cfg_data_i[5:0];
          ksm_pkg::CfgDupIgnore: dup_ignore_q <= cfg_data_i[0];
          ksm_pkg::CfgMinDiag:   min_diag_q   <= $signed(cfg_data_i);
          ksm_pkg::CfgMaxDiag:   max_diag_q   <= $signed(cfg_data_i);
          default: ;
        endcase
      end
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (accept) begin
            op_q     <= operation_i;
            pos_q    <= position_i;
            idx_q    <= entry_index_i;
            status_q <= 1'b0;
            hv_q     <= 1'b0;
            ha_q     <= '0;
            hb_q     <= '0;
            hl_q     <= '0;
            addr_q   <= '0;
            pend_q   <= 1'b0;
            case (operation_i)
              ksm_pkg::OpClear: begin
                count_q     <= '0;
                out_valid_q <= 1'b1;
              end
              ksm_pkg::OpBaseA, ksm_pkg::OpBaseB: begin
                kmer_q   <= kmer_d;
                vshift_q <= vshift_d;
                if (vshift_d == '0) state_q <= StSearch;
                else out_valid_q <= 1'b1;
              end
              ksm_pkg::OpRead: state_q <= StRead;
              default: ;
            endcase
          end
        end
        StSearch: begin
          if (match) begin
            out_valid_q <= 1'b1;
            state_q     <= StIdle;
          end else if (addr_q < count_q) begin
            pend_q <= 1'b1;
            pidx_q <= addr_q[ksm_pkg::AddrBits-1:0];
            addr_q <= addr_q + 1'b1;
          end else begin
            // not found: insert for read a (status flag if the table is full), nothing for read b
            if (op_q == ksm_pkg::OpBaseA) begin
              if (count_q < ksm_pkg::CntBits'(ksm_pkg::TableDepth)) count_q <= count_q + 1'b1;
              else status_q <= 1'b1;
            end
            out_valid_q <= 1'b1;
            state_q     <= StIdle;
          end
        end
        StRead: begin
          if ({1'b0, idx_q} < count_q && rdata.b_state == ksm_pkg::BRec && !rdata.a_dup) begin
            hv_q <= 1'b1;
            ha_q <= rdata.a_pos;
            hb_q <= rdata.b_pos;
            hl_q <= k_eff;
          end
          out_valid_q <= 1'b1;
          state_q     <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  `ASSERT_CLK(a_count_bound, count_q <= ksm_pkg::CntBits'(ksm_pkg::TableDepth), "count above depth")
  `ASSERT_CLK(a_write_busy, !we || state_q == StSearch, "table write outside search")
  `ASSERT_NEXT(a_search_done, state_q == StSearch && match, out_valid_q && state_q == StIdle, "match gave no beat")
endmodule

// ===== verif/tb_kmer_seed_table_matcher.sv =====
// testbench for the k-mer seed table matcher: predicted results checked beat by beat
module tb_kmer_seed_table_matcher;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        status;
    logic        hit_valid;
    logic [19:0] hit_a_pos;
    logic [19:0] hit_b_pos;
    logic [5:0]  hit_length;
  } seed_result_t;

  class seed_scoreboard;
    logic [5:0]   mer_size;
    logic         dup_ignore;
    logic [20:0]  min_diag;
    logic [20:0]  max_diag;
    logic [63:0]  kmer_reg;
    logic [63:0]  valid_reg;
    logic [63:0]  slot_kmer[ksm_pkg::TableDepth];
    logic [19:0]  slot_a_pos[ksm_pkg::TableDepth];
    logic         slot_a_dup[ksm_pkg::TableDepth];
    logic [19:0]  slot_b_pos[ksm_pkg::TableDepth];
    logic [1:0]   slot_b_state[ksm_pkg::TableDepth];
    int unsigned  slot_count;
    seed_result_t pending_q[$];
    int unsigned  errors;
    int unsigned  n_checked;
    int unsigned  n_hits;
    int unsigned  n_full;

    function new();
      mer_size = 6'd16;
      dup_ignore = 1'b1;
      min_diag = '0;
      max_diag = '0;
      kmer_reg = '0;
      valid_reg = '1;
      slot_count = 0;
      errors = 0;
      n_checked = 0;
      n_hits = 0;
      n_full = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [20:0] data);
      case (idx)
        ksm_pkg::CfgMerSize:   mer_size = data[5:0];
        ksm_pkg::CfgDupIgnore: dup_ignore = data[0];
        ksm_pkg::CfgMinDiag:   min_diag = data;
        default:               max_diag = data;
      endcase
    endfunction

    function logic [5:0] kmer_len();
      if (mer_size == 0) return 6'd1;
      if (mer_size > 32) return 6'd32;
      return mer_size;
    endfunction

    function bit shift_in(logic [7:0] ch, logic rs);
      logic [63:0] mask;
      logic [1:0]  code;
      logic [1:0]  bad;
      mask = (kmer_len() == 32) ? '1 : ((64'd1 << (2 * kmer_len())) - 1);
      bad = 2'd0;
      case (ch)
        "A", "a": code = 2'd0;
        "C", "c": code = 2'd1;
        "G", "g": code = 2'd2;
        "T", "t": code = 2'd3;
        default: begin
          code = 2'd0;
          bad = 2'd3;
        end
      endcase
      if (rs) begin
        kmer_reg = '0;
        valid_reg = '1;
      end
      kmer_reg = ((kmer_reg << 2) | code) & mask;
      valid_reg = ((valid_reg << 2) | bad) & mask;
      return valid_reg == 0;
    endfunction

    function int lookup(logic [63:0] km);
      for (int i = 0; i < slot_count; i++)
        if (slot_kmer[i] == km) return i;
      return -1;
    endfunction

    function void note_input(logic [1:0] op, logic rs, logic [7:0] ch, logic [19:0] pos,
                             logic [9:0] idx);
      seed_result_t r;
      int s;
      logic [19:0] start;
      longint diag;
      r = '0;
      start = pos + 20'd1 - 20'(kmer_len());
      case (op)
        ksm_pkg::OpClear: slot_count = 0;
        ksm_pkg::OpBaseA: if (shift_in(ch, rs)) begin
          s = lookup(kmer_reg);
          if (s >= 0) begin
            if (dup_ignore) slot_a_dup[s] = 1'b1;
          end else if (slot_count < ksm_pkg::TableDepth) begin
            slot_kmer[slot_count] = kmer_reg;
            slot_a_pos[slot_count] = start;
            slot_a_dup[slot_count] = 1'b0;
            slot_b_pos[slot_count] = '0;
            slot_b_state[slot_count] = ksm_pkg::BNone;
            slot_count++;
          end else begin
            r.status = 1'b1;
            n_full++;
          end
        end
        ksm_pkg::OpBaseB: if (shift_in(ch, rs)) begin
          s = lookup(kmer_reg);
          if (s >= 0 && !slot_a_dup[s]) begin
            diag = longint'(slot_a_pos[s]) - longint'(start);
            if (diag >= longint'($signed(min_diag)) && diag <= longint'($signed(max_diag))) begin
              if (slot_b_state[s] != ksm_pkg::BNone) begin
                if (dup_ignore) slot_b_state[s] = ksm_pkg::BDup;
              end else begin
                slot_b_state[s] = ksm_pkg::BRec;
                slot_b_pos[s] = start;
              end
            end
          end
        end
        default: if (idx < slot_count && slot_b_state[idx] == ksm_pkg::BRec &&
                     !slot_a_dup[idx]) begin
          r.hit_valid = 1'b1;
          r.hit_a_pos = slot_a_pos[idx];
          r.hit_b_pos = slot_b_pos[idx];
          r.hit_length = kmer_len();
          n_hits++;
        end
      endcase
      pending_q = {pending_q, r};
    endfunction

    function void check_result(seed_result_t got);
      seed_result_t exp;
      if (pending_q.size() == 0) begin
        $display("%0t: result with nothing expected, actual %p", $time, got);
        errors++;
        return;
      end
      exp = pending_q.pop_front();
      n_checked++;
      if (got.status !== exp.status) begin
        $display("%0t: status expected %0d actual %0d", $time, exp.status, got.status);
        errors++;
      end
      if (got.hit_valid !== exp.hit_valid) begin
        $display("%0t: hit_valid expected %0d actual %0d", $time, exp.hit_valid, got.hit_valid);
        errors++;
      end
      if (got.hit_a_pos !== exp.hit_a_pos) begin
        $display("%0t: hit_a_pos expected %0d actual %0d", $time, exp.hit_a_pos, got.hit_a_pos);
        errors++;
      end
      if (got.hit_b_pos !== exp.hit_b_pos) begin
        $display("%0t: hit_b_pos expected %0d actual %0d", $time, exp.hit_b_pos, got.hit_b_pos);
        errors++;
      end
      if (got.hit_length !== exp.hit_length) begin
        $display("%0t: hit_length expected %0d actual %0d", $time, exp.hit_length,
                 got.hit_length);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  operation_i;
  logic        restart_i;
  logic [7:0]  base_char_i;
  logic [19:0] position_i;
  logic [9:0]  entry_index_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        status_o;
  logic        hit_valid_o;
  logic [19:0] hit_a_pos_o;
  logic [19:0] hit_b_pos_o;
  logic [5:0]  hit_length_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [20:0] cfg_data_i;

  seed_scoreboard sb;
  int unsigned    stall_hold;
  int unsigned    burst_left;
  int unsigned    n_sent;
  int unsigned    n_seq_a;
  int unsigned    n_seq_b;

  kmer_seed_table_matcher i_dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

  // receiver: random stall pattern, plus long hold-offs on request
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_hold > 0) begin
        stall_hold--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 3) != 0) || (($time / 400) % 3 == 0);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result({status_o, hit_valid_o, hit_a_pos_o, hit_b_pos_o, hit_length_o});
  end

  // valid stays up between beats of a burst; the next call puts the new payload on
  task automatic send_item(logic [1:0] op, logic rs, logic [7:0] ch, logic [19:0] pos,
                           logic [9:0] idx);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, 1) ? $urandom_range(1, 6) : 0;
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    operation_i <= op;
    restart_i <= rs;
    base_char_i <= ch;
    position_i <= pos;
    entry_index_i <= idx;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(op, rs, ch, pos, idx);
    n_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [20:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_base();
    case ($urandom_range(0, 7))
      0: return "A";
      1: return "C";
      2: return "G";
      3: return "T";
      4: return "a";
      5: return "c";
      6: return "g";
      default: return "t";
    endcase
  endfunction

  function automatic logic [7:0] pick_char();
    if ($urandom_range(0, 19) == 0) return 8'($urandom);
    return pick_base();
  endfunction

  // read A then read B sharing sequence, with random mutations, then read back slots
  task automatic run_pair(int len, int shift);
    logic [7:0] seq[];
    logic [19:0] a0;
    logic [19:0] b0;
    seq = new[len];
    foreach (seq[i]) seq[i] = pick_char();
    a0 = 20'($urandom);
    b0 = a0 - 20'(shift);
    send_item(ksm_pkg::OpClear, 1'($urandom), 8'($urandom), 20'($urandom), 10'($urandom));
    for (int i = 0; i < len; i++)
      send_item(ksm_pkg::OpBaseA, i == 0, seq[i], a0 + 20'(i), 10'($urandom));
    for (int i = 0; i < len; i++)
      send_item(ksm_pkg::OpBaseB, i == 0, ($urandom_range(0, 9) == 0) ? pick_base() : seq[i],
                b0 + 20'(i), 10'($urandom));
    for (int i = 0; i < sb.slot_count + 1 && i < 24; i++)
      send_item(ksm_pkg::OpRead, 1'($urandom), 8'($urandom), 20'($urandom), 10'(i));
  endtask

  initial begin
    sb = new();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    operation_i = '0;
    restart_i = 1'b0;
    base_char_i = '0;
    position_i = '0;
    entry_index_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    stall_hold = 0;
    burst_left = 0;
    n_sent = 0;
    n_seq_a = 0;
    n_seq_b = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: default config, wrap of start position, junk chars, reads out of range
    send_item(ksm_pkg::OpRead, 1'b1, 8'hff, 20'hfffff, 10'h3ff);
    send_item(ksm_pkg::OpBaseA, 1'b1, "A", 20'd0, 10'd0);
    send_item(ksm_pkg::OpBaseA, 1'b0, "C", 20'd1, 10'd0);
    send_item(ksm_pkg::OpBaseA, 1'b0, "G", 20'd2, 10'd0);
    send_item(ksm_pkg::OpBaseA, 1'b0, "T", 20'd3, 10'd0);
    drain();
    write_cfg(ksm_pkg::CfgMerSize, 21'd0);
    write_cfg(ksm_pkg::CfgMerSize, 21'd2);
    write_cfg(ksm_pkg::CfgDupIgnore, 21'd1);
    write_cfg(ksm_pkg::CfgMinDiag, 21'h100001);
    write_cfg(ksm_pkg::CfgMaxDiag, 21'h0fffff);
    send_item(ksm_pkg::OpClear, 1'b1, 8'd0, 20'd0, 10'd0);
    send_item(ksm_pkg::OpBaseA, 1'b1, "a", 20'd0, 10'd0);
    send_item(ksm_pkg::OpBaseA, 1'b0, "c", 20'hfffff, 10'd0);
    send_item(ksm_pkg::OpBaseA, 1'b0, "N", 20'd2, 10'd0);
    send_item(ksm_pkg::OpBaseA, 1'b0, "G", 20'd3, 10'd0);
    send_item(ksm_pkg::OpBaseA, 1'b0, "t", 20'd4, 10'd0);
    send_item(ksm_pkg::OpBaseA, 1'b0, "A", 20'd5, 10'd0);
    send_item(ksm_pkg::OpBaseA, 1'b0, "C", 20'd6, 10'd0);
    send_item(ksm_pkg::OpBaseB, 1'b1, "A", 20'd0, 10'd0);
    send_item(ksm_pkg::OpBaseB, 1'b0, "C", 20'd1, 10'd0);
    send_item(ksm_pkg::OpBaseB, 1'b0, "G", 20'd2, 10'd0);
    send_item(ksm_pkg::OpBaseB, 1'b0, "T", 20'd3, 10'd0);
    send_item(ksm_pkg::OpBaseA, 1'b1, "T", 20'd8, 10'd0);
    send_item(ksm_pkg::OpBaseA, 1'b0, "A", 20'd9, 10'd0);
    for (int i = 0; i < 5; i++) send_item(ksm_pkg::OpRead, 1'b0, 8'd0, 20'd0, 10'(i));
    send_item(ksm_pkg::OpRead, 1'b0, 8'd0, 20'd0, 10'h3ff);
    drain();

    // random phases over several settings
    for (int ph = 0; ph < 16; ph++) begin
      write_cfg(ksm_pkg::CfgMerSize, (ph == 1) ? 21'd32 : (ph == 2) ? 21'd63 :
                (ph == 3) ? 21'd1 : 21'($urandom_range(1, 8)));
      write_cfg(ksm_pkg::CfgDupIgnore, 21'(ph % 2));
      if (ph % 4 == 3) begin
        write_cfg(ksm_pkg::CfgMinDiag, 21'h100001);
        write_cfg(ksm_pkg::CfgMaxDiag, 21'h0fffff);
      end else begin
        write_cfg(ksm_pkg::CfgMinDiag, 21'($signed($urandom_range(0, 8)) - 4));
        write_cfg(ksm_pkg::CfgMaxDiag, 21'($urandom_range(0, 6)));
      end
      if (ph == 5) stall_hold = 300;
      run_pair($urandom_range(8, 20), $urandom_range(0, 3) - 1);
      n_seq_a++;
      n_seq_b++;
      for (int i = 0; i < 4; i++)
        send_item(2'($urandom), 1'($urandom), 8'($urandom), 20'($urandom), 10'($urandom));
      drain();
      if (n_sent > 560) break;
    end
    repeat (20) @(posedge clk_i);

    $display("covered %0d items in %0d read pairs, %0d beats checked, %0d seed hits, %0d drops",
             n_sent, n_seq_a, sb.n_checked, sb.n_hits, sb.n_full);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
